// ===== hw/rtl/vna_pkg.sv =====
// ============================================================================
// vna_pkg: shared types and constants for the vertex normal averager
// Request codes, sequencer states, store depth and fixed-point constants.
// ============================================================================
package vna_pkg;

    localparam int VERTEX_DEPTH = 64;
    localparam int IDX_W        = 6;
    localparam int ACC_W        = 24;
    localparam int CNT_W        = 7;
    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_TRI    = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_CROSS,
        ST_SHIFT,
        ST_SUMSQ,
        ST_SQRT,
        ST_DIV,
        ST_ADD,
        ST_FRD,
        ST_FWAIT,
        ST_EMIT
    } state_t;

    // Handshake between sequencer and the shared divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

// ===== hw/rtl/vna_div.sv =====
// ============================================================================
// vna_div: restoring divider, one quotient bit per cycle
// Computes floor(num / den) for 48-bit numerator and 32-bit divisor.
// ============================================================================
module vna_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [47:0]         num,
    input  logic [31:0]         den,
    output vna_pkg::div_ctl_t   ctl,
    output logic [47:0]         quot
);
    import vna_pkg::*;

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [47:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] trial;

    // Shift in one numerator bit and try a subtract
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg[31:0], q_reg[47]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            q_next    = num;
            rem_next  = 33'd0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot      = q_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

    ast_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without busy");
    ast_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider restarted while busy");
    ast_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done longer than a cycle");

endmodule

// ===== hw/rtl/vertex_normal_averager.sv =====
// ============================================================================
// vertex_normal_averager: smooth vertex normals from face normals
// Loads positions and initial normals, accumulates unit face normals per corner, and on finish
// emits a unit normal per vertex, all through one shared multiply/divide path.
// ============================================================================
//  channel | dir | beat
//  cfg     | in  | vertex_count
//  s_axis  | in  | request (type in tuser, indices and data in tdata)
//  m_axis  | out | vertex normal (last on final vertex)
//
//  Load: the stores are written when the request is taken; s_axis_tready stays high.
//  Triangle: read three positions, cross product, scale shift, sum of squares, square root,
//  three divisions, then read-modify-write of the three corner accumulators.
//  Finish: per vertex, read, normalize and emit; a zero accumulator skips normalizing; output stalls hold.
//  Reset clears control only; stores are undefined until loaded.
//  s_axis_tready is low while an item is worked; a stalled output beat holds.
module vertex_normal_averager
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: index_a, index_b, index_c, pos_x, pos_y, pos_z, init_nx, init_ny, init_nz
    input  logic [119:0] s_axis_tdata,
    // tuser: req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_index, norm_x, norm_y, norm_z (padded)
    output logic [55:0] m_axis_tdata,
    // tuser: zero_flag
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    import vna_pkg::*;

    // stores
    logic [47:0] pos_mem [VERTEX_DEPTH];
    logic [71:0] acc_mem [VERTEX_DEPTH];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] ia_reg, ib_reg, ic_reg, vi_reg;
    logic [1:0]  k_reg;
    logic [47:0] pa_reg, pb_reg, pc_reg;
    logic [40:0] m_reg [3];
    logic        neg_reg [3];
    logic [63:0] sum_reg;
    logic [63:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [15:0] n_reg [3];
    logic [5:0]  step_reg;
    logic        acc_upd_reg;
    logic [71:0] acc_rd_reg;

    // divider
    logic        div_start;
    logic [47:0] div_num, div_quot;
    div_ctl_t    div_ctl;
    logic [31:0] len;
    assign len = sq_r_reg[31:0];

    vna_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (len),
        .ctl   (div_ctl),
        .quot  (div_quot)
    );

    logic acc_in;
    logic out_free;
    logic [CNT_W-1:0] eff_cnt;
    assign acc_in   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign eff_cnt  = (count_reg == '0) ? 7'd1 :
                      (count_reg > 7'(VERTEX_DEPTH)) ? 7'(VERTEX_DEPTH) : count_reg;
    assign cfg_ready = (state_reg == ST_IDLE);

    logic [1:0] rq;
    assign rq = s_axis_tuser;
    logic [5:0] in_a, in_b, in_c;
    assign in_a = s_axis_tdata[5:0];
    assign in_b = s_axis_tdata[11:6];
    assign in_c = s_axis_tdata[17:12];

    // shared multiplier operands
    logic signed [16:0] e1 [3], e2 [3];
    logic signed [16:0] mul_a, mul_b, mul_c, mul_d;
    logic signed [33:0] prod_ab, prod_cd;
    logic signed [34:0] prod_c;
    logic [30:0] msq;
    logic [61:0] msq_p;
    logic [1:0] kp1, kp2;
    assign kp1 = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
    assign kp2 = (kp1 == 2'd2) ? 2'd0 : kp1 + 2'd1;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = 17'(signed'(pb_reg[16*k +: 16])) - 17'(signed'(pa_reg[16*k +: 16]));
            e2[k] = 17'(signed'(pc_reg[16*k +: 16])) - 17'(signed'(pa_reg[16*k +: 16]));
        end
        mul_a   = e1[kp1];
        mul_b   = e2[kp2];
        mul_c   = e1[kp2];
        mul_d   = e2[kp1];
        prod_ab = 34'(mul_a) * 34'(mul_b);
        prod_cd = 34'(mul_c) * 34'(mul_d);
        prod_c  = 35'(prod_ab) - 35'(prod_cd);
        msq     = m_reg[k_reg][30:0];
        msq_p   = 62'(msq) * 62'(msq);
    end

    // shift to fit 31 bits
    logic [40:0] mx;
    always_comb
    begin
        mx = m_reg[0] | m_reg[1] | m_reg[2];
    end

    // divider numerator
    assign div_num = 48'({m_reg[k_reg][30:0], 14'd0}) + 48'(len[31:1]);

    // saturating accumulate into read word
    logic [71:0] acc_sum;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [24:0] s;
            s = 25'(signed'(acc_rd_reg[24*k +: 24])) + 25'(signed'(n_reg[k]));
            if (s > 25'sd8388607)
                acc_sum[24*k +: 24] = 24'h7FFFFF;
            else if (s < -25'sd8388608)
                acc_sum[24*k +: 24] = 24'h800000;
            else
                acc_sum[24*k +: 24] = s[23:0];
        end
    end

    // corner picked by the update step: two steps per corner
    logic [5:0] add_idx;
    always_comb
    begin
        unique case (step_reg[2:1])
            2'd0:    add_idx = ia_reg;
            2'd1:    add_idx = ib_reg;
            default: add_idx = ic_reg;
        endcase
    end

    logic is_fin;
    logic fin_reg;
    logic [15:0] q16;
    assign q16 = neg_reg[k_reg] ? 16'(-div_quot[15:0]) : div_quot[15:0];
    assign is_fin = fin_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (acc_in)
                begin
                    unique case (rq)
                        REQ_TRI:    state_next = ST_RD_A;
                        REQ_FINISH: state_next = ST_FRD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            ST_RD_A:  state_next = ST_RD_B;
            ST_RD_B:  state_next = ST_RD_C;
            ST_RD_C:  state_next = ST_CROSS;
            ST_CROSS: if (k_reg == 2'd2) state_next = ST_SHIFT;
            ST_SHIFT:
                if (mx == '0) state_next = is_fin ? ST_EMIT : ST_IDLE;
                else if (mx[40:31] == '0) state_next = ST_SUMSQ;
            ST_SUMSQ: if (k_reg == 2'd2) state_next = ST_SQRT;
            ST_SQRT:  if (sq_bit_reg == '0) state_next = ST_DIV;
            ST_DIV:
                if (div_ctl.done && k_reg == 2'd2)
                    state_next = is_fin ? ST_EMIT : ST_ADD;
            ST_ADD:   if (step_reg == 6'd5) state_next = ST_IDLE;
            ST_FRD:   state_next = ST_FWAIT;
            ST_FWAIT: state_next = ST_SHIFT;
            ST_EMIT:
                if (out_free)
                    state_next = (vi_reg == 6'(eff_cnt - 7'd1)) ? ST_IDLE : ST_FRD;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DIV) && !div_ctl.busy && !div_ctl.done &&
                    !acc_upd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_RESET;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
            if (state_reg == ST_EMIT && out_free)
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        acc_upd_reg <= (state_reg == ST_DIV) && div_ctl.done;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_reg <= 2'd0;
                step_reg <= 6'd0;
                vi_reg <= 6'd0;
                fin_reg <= (rq == REQ_FINISH);
                ia_reg <= in_a;
                ib_reg <= in_b;
                ic_reg <= in_c;
                if (acc_in && rq == REQ_LOAD)
                begin
                    pos_mem[in_a] <= s_axis_tdata[65:18];
                    acc_mem[in_a] <= {{8{s_axis_tdata[113]}}, s_axis_tdata[113:98],
                                      {8{s_axis_tdata[97]}}, s_axis_tdata[97:82],
                                      {8{s_axis_tdata[81]}}, s_axis_tdata[81:66]};
                end
            end
            ST_RD_A: pa_reg <= pos_mem[ia_reg];
            ST_RD_B: pb_reg <= pos_mem[ib_reg];
            ST_RD_C: pc_reg <= pos_mem[ic_reg];
            ST_CROSS:
            begin
                m_reg[k_reg]   <= prod_c[34] ? 41'(-prod_c) : 41'(prod_c);
                neg_reg[k_reg] <= prod_c[34];
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                sum_reg <= '0;
            end
            ST_SHIFT:
            begin
                if (mx == '0)
                begin
                    for (int k = 0; k < 3; k++) n_reg[k] <= '0;
                end
                else if (mx[40:31] != '0)
                begin
                    for (int k = 0; k < 3; k++) m_reg[k] <= m_reg[k] >> 1;
                end
                k_reg <= 2'd0;
                sum_reg <= '0;
            end
            ST_SUMSQ:
            begin
                sum_reg <= sum_reg + 64'(msq_p);
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                sq_r_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
                sq_v_reg <= sum_reg + 64'(msq_p);
            end
            ST_SQRT:
            begin
                if (sq_bit_reg != '0)
                begin
                    if (sq_v_reg >= sq_r_reg + sq_bit_reg)
                    begin
                        sq_v_reg <= sq_v_reg - (sq_r_reg + sq_bit_reg);
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_r_reg <= sq_r_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
                k_reg <= 2'd0;
            end
            ST_DIV:
            begin
                if (div_ctl.done)
                begin
                    n_reg[k_reg] <= q16;
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                step_reg <= 6'd0;
            end
            ST_ADD:
            begin
                if (!step_reg[0])
                    acc_rd_reg <= acc_mem[add_idx];
                else
                    acc_mem[add_idx] <= acc_sum;
                step_reg <= step_reg + 6'd1;
            end
            ST_FRD:  acc_rd_reg <= acc_mem[vi_reg];
            ST_FWAIT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic signed [23:0] a;
                    a = acc_rd_reg[24*k +: 24];
                    m_reg[k]   <= a[23] ? 41'(-42'(a)) : 41'(a);
                    neg_reg[k] <= a[23];
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    acc_mem[vi_reg] <= {{8{n_reg[2][15]}}, n_reg[2],
                                        {8{n_reg[1][15]}}, n_reg[1],
                                        {8{n_reg[0][15]}}, n_reg[0]};
                    m_axis_tdata <= {2'b0, n_reg[2], n_reg[1], n_reg[0], vi_reg};
                    m_axis_tuser <= (mx == '0);
                    m_axis_tlast <= (vi_reg == 6'(eff_cnt - 7'd1));
                    vi_reg <= vi_reg + 6'd1;
                end
            end
            default: ;
        endcase
    end

    logic unused_ok;
    assign unused_ok = ^{div_ctl.start, div_quot[47:16], s_axis_tdata[119:114]};

    ast_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("accepting during work");
    ast_emit_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("output beat outside emit");
    ast_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> state_reg == ST_IDLE)
        else $error("config while busy");

endmodule
